@@ design/tiih_pkg.sv @@
// tiih_pkg: shared types and constants of the thermocouple filter and heater block
// word layouts, register indexes, conversion and filter coefficients
// no dependencies

package tiih_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HIGH_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_GUARD_TICKS    = 2'd2;

  localparam int unsigned CfgDataW = 18;

  localparam logic [17:0] LOW_THRESHOLD_RST  = 18'd7680;
  localparam logic [17:0] HIGH_THRESHOLD_RST = 18'd10240;
  localparam logic [9:0]  GUARD_TICKS_RST    = 10'd20;

  // adc code to 1/256 C: floor((adc*64000 + 620) / 1241)
  localparam logic [27:0] ADC_NUM  = 28'd64000;
  localparam logic [27:0] ADC_HALF = 28'd620;
  // ceil(2^40 / 1241), exact quotient for every numerator below 2^28
  localparam logic [29:0] ADC_RECIP = 30'd885988419;
  localparam int unsigned ADC_RECIP_SH = 40;
  localparam logic signed [20:0] RAW_OFFSET = 21'sd34048;

  // filter coefficients, q.30
  localparam logic signed [23:0] COEF_B0 = 24'sd2676301;
  localparam logic signed [23:0] COEF_B1 = 24'sd5352603;
  localparam logic signed [31:0] COEF_A1 = 32'sd2061584302;
  localparam logic signed [31:0] COEF_A2 = 32'sd998579896;

  localparam logic [10:0] COUNT_MAX = 11'd2047;

  typedef struct packed {
    logic              mode;
    logic [11:0]       adc_sample;
    logic signed [15:0] cold_junction_temp;
  } tiih_in_t;

  typedef struct packed {
    logic signed [19:0] raw_temp;
    logic signed [19:0] filtered_temp;
    logic               heater_on;
  } tiih_out_t;

  // converted sample between the front end and the filter
  typedef struct packed {
    logic               mode;
    logic signed [15:0] cold;
    logic signed [19:0] raw;
  } tiih_raw_t;

  typedef struct packed {
    logic [17:0] low_threshold;
    logic [17:0] high_threshold;
    logic [9:0]  guard_ticks;
  } tiih_cfg_t;

endpackage

@@ design/tiih_adc_conv.sv @@
// tiih_adc_conv: three-stage front end, adc code plus cold junction to raw temperature
// depends on tiih_pkg

module tiih_adc_conv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 up_valid_i,
  output logic                 up_ready_o,
  input  tiih_pkg::tiih_in_t   up_data_i,
  output logic                 dn_valid_o,
  input  logic                 dn_ready_i,
  output tiih_pkg::tiih_raw_t  dn_data_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic               mode1_q, mode2_q;
  logic signed [15:0] cold1_q, cold2_q;
  logic [27:0]        num_q;
  logic [17:0]        quot_q;
  tiih_pkg::tiih_raw_t raw_q;

  logic [27:0]        num_d;
  logic [57:0]        prod;
  logic [17:0]        quot_d;
  logic signed [20:0] raw_wide;
  logic signed [19:0] raw_sat;

  assign rdy3 = !v3_q || dn_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign up_ready_o = rdy1;

  assign num_d  = 28'(up_data_i.adc_sample) * tiih_pkg::ADC_NUM + tiih_pkg::ADC_HALF;
  assign prod   = 58'(num_q) * 58'(tiih_pkg::ADC_RECIP);
  assign quot_d = prod[57:tiih_pkg::ADC_RECIP_SH];

  assign raw_wide = $signed({3'b000, quot_q}) - tiih_pkg::RAW_OFFSET
                    + 21'(cold2_q);

  always_comb begin
    if (raw_wide[20] != raw_wide[19]) begin
      raw_sat = raw_wide[20] ? 20'sh80000 : 20'sh7FFFF;
    end else begin
      raw_sat = raw_wide[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= up_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && rdy1) begin
      num_q   <= num_d;
      mode1_q <= up_data_i.mode;
      cold1_q <= up_data_i.cold_junction_temp;
    end
    if (v1_q && rdy2) begin
      quot_q  <= quot_d;
      mode2_q <= mode1_q;
      cold2_q <= cold1_q;
    end
    if (v2_q && rdy3) begin
      raw_q.mode <= mode2_q;
      raw_q.cold <= cold2_q;
      // seed words pass the cold junction value straight through
      raw_q.raw  <= mode2_q ? 20'(cold2_q) : raw_sat;
    end
  end

  assign dn_valid_o = v3_q;
  assign dn_data_o  = raw_q;

endmodule

@@ design/tiih_filter.sv @@
// tiih_filter: biquad low-pass (feed-forward stage, feedback stage) and heater hysteresis
// depends on tiih_pkg

module tiih_filter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tiih_pkg::tiih_cfg_t  cfg_i,
  input  logic                 up_valid_i,
  output logic                 up_ready_o,
  input  tiih_pkg::tiih_raw_t  up_data_i,
  output logic                 dn_valid_o,
  input  logic                 dn_ready_i,
  output tiih_pkg::tiih_out_t  dn_data_o
);

  localparam logic signed [64:0] ROUND_Q30 = 65'sd536870912;

  logic v4_q, v5_q;
  logic rdy4, rdy5;

  // feed-forward stage
  logic               mode4_q;
  logic signed [15:0] cold4_q;
  logic signed [19:0] raw4_q;
  logic signed [52:0] ff4_q;
  logic signed [19:0] xh0_q, xh1_q;

  // feedback stage and result
  logic signed [31:0] yh0_q, yh1_q;
  logic [10:0]        count_q;
  logic               heater_q;
  tiih_pkg::tiih_out_t out_q;

  logic signed [20:0] xsum;
  logic signed [44:0] m0, m1;
  logic signed [52:0] ff_d;
  logic signed [64:0] acc;
  logic signed [34:0] y35;
  logic signed [31:0] y32;
  logic signed [32:0] yr;
  logic signed [24:0] f25;
  logic signed [19:0] filt;
  logic               allowed;
  logic               heater_d;

  assign rdy5 = !v5_q || dn_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign up_ready_o = rdy4;

  // b0 and b2 are equal, so pair x0 with x2
  assign xsum = 21'(up_data_i.raw) + 21'(xh1_q);
  assign m0   = 45'(xsum) * 45'(tiih_pkg::COEF_B0);
  assign m1   = 45'(xh0_q) * 45'(tiih_pkg::COEF_B1);
  assign ff_d = 53'(m0 + m1) <<< 8;

  assign acc = 65'(ff4_q) + 65'(tiih_pkg::COEF_A1) * 65'(yh0_q)
               - 65'(tiih_pkg::COEF_A2) * 65'(yh1_q) + ROUND_Q30;
  assign y35 = acc[64:30];

  always_comb begin
    if ((y35[34:31] != 4'b0000) && (y35[34:31] != 4'b1111)) begin
      y32 = y35[34] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      y32 = y35[31:0];
    end
  end

  assign yr  = 33'(y32) + 33'sd128;
  assign f25 = yr[32:8];

  always_comb begin
    if ((f25[24:19] != 6'b000000) && (f25[24:19] != 6'b111111)) begin
      filt = f25[24] ? 20'sh80000 : 20'sh7FFFF;
    end else begin
      filt = f25[19:0];
    end
  end

  assign allowed = count_q > 11'(cfg_i.guard_ticks);

  always_comb begin
    heater_d = heater_q;
    if (allowed && ($signed({filt[19], filt}) < $signed({3'b000, cfg_i.low_threshold}))) begin
      heater_d = 1'b1;
    end
    // off wins when both thresholds are crossed
    if (allowed && ($signed({filt[19], filt}) > $signed({3'b000, cfg_i.high_threshold}))) begin
      heater_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      xh0_q    <= '0;
      xh1_q    <= '0;
      yh0_q    <= '0;
      yh1_q    <= '0;
      count_q  <= '0;
      heater_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= up_valid_i;
      if (rdy5) v5_q <= v4_q;
      if (up_valid_i && rdy4) begin
        if (up_data_i.mode) begin
          xh0_q <= 20'(up_data_i.cold);
          xh1_q <= 20'(up_data_i.cold);
        end else begin
          xh0_q <= up_data_i.raw;
          xh1_q <= xh0_q;
        end
      end
      if (v4_q && rdy5) begin
        if (mode4_q) begin
          yh0_q   <= {{8{cold4_q[15]}}, cold4_q, 8'h00};
          yh1_q   <= {{8{cold4_q[15]}}, cold4_q, 8'h00};
          count_q <= '0;
        end else begin
          yh0_q    <= y32;
          yh1_q    <= yh0_q;
          heater_q <= heater_d;
          if (count_q < tiih_pkg::COUNT_MAX) begin
            count_q <= count_q + 11'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && rdy4) begin
      mode4_q <= up_data_i.mode;
      cold4_q <= up_data_i.cold;
      raw4_q  <= up_data_i.raw;
      ff4_q   <= ff_d;
    end
    if (v4_q && rdy5) begin
      out_q.raw_temp <= raw4_q;
      if (mode4_q) begin
        out_q.filtered_temp <= 20'(cold4_q);
        out_q.heater_on     <= heater_q;
      end else begin
        out_q.filtered_temp <= filt;
        out_q.heater_on     <= heater_d;
      end
    end
  end

  assign dn_valid_o = v5_q;
  assign dn_data_o  = out_q;

endmodule

@@ design/thermocouple_iir_hysteresis_heater.sv @@
// thermocouple_iir_hysteresis_heater: top level, configuration registers and the two stages
// depends on tiih_pkg, tiih_adc_conv, tiih_filter
//
// channel   direction  handshake                  word
// in        input      in_valid_i / in_ready_o     tiih_in_t  (mode, adc_sample, cold)
// out       output     out_valid_o / out_ready_i   tiih_out_t (raw, filtered, heater_on)
// cfg       input      cfg_we_i                    cfg_index_i, cfg_wdata_i
//
// one word per cycle sustained while out_ready_i is high, five register stages
// the rate is set by the filter feedback stage: two constant multiplies and an add per cycle
// each stage has its own valid bit and loads when empty or when it drains, so bubbles fill
// while the output register holds a word that has not been taken
// reset clears valid bits, filter history, sample count, heater and loads register defaults

module thermocouple_iir_hysteresis_heater (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tiih_pkg::tiih_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tiih_pkg::tiih_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [tiih_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tiih_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  tiih_pkg::tiih_cfg_t cfg_q;
  tiih_pkg::tiih_raw_t raw_word;
  logic                raw_valid;
  logic                raw_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold  <= tiih_pkg::LOW_THRESHOLD_RST;
      cfg_q.high_threshold <= tiih_pkg::HIGH_THRESHOLD_RST;
      cfg_q.guard_ticks    <= tiih_pkg::GUARD_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tiih_pkg::REG_LOW_THRESHOLD: begin
          cfg_q.low_threshold <= cfg_wdata_i;
        end
        tiih_pkg::REG_HIGH_THRESHOLD: begin
          cfg_q.high_threshold <= cfg_wdata_i;
        end
        tiih_pkg::REG_GUARD_TICKS: begin
          cfg_q.guard_ticks <= cfg_wdata_i[9:0];
        end
        default: begin
        end
      endcase
    end
  end

  tiih_adc_conv u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .up_ready_o (in_ready_o),
    .up_data_i  (in_data_i),
    .dn_valid_o (raw_valid),
    .dn_ready_i (raw_ready),
    .dn_data_o  (raw_word)
  );

  tiih_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .up_valid_i (raw_valid),
    .up_ready_o (raw_ready),
    .up_data_i  (raw_word),
    .dn_valid_o (out_valid_o),
    .dn_ready_i (out_ready_i),
    .dn_data_o  (out_data_o)
  );

endmodule
